[design/alts_pkg.sv]
// Shared constants for the adaptive light threshold switch.
`default_nettype none

package alts_pkg;

  localparam int ADC_BITS_DEF = 12;   // default sample width
  localparam int NUM_SAMPLES  = 8;    // samples per word
  localparam int SAMPLE_SHIFT = 3;    // log2 of NUM_SAMPLES
  localparam int TIME_W       = 32;   // timestamp width
  localparam int DELAY_W      = 16;   // debounce delay register width

  localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(50);

  // Word widths, rounded up to whole bytes.
  function automatic int in_width(input int adc_bits);
    return ((NUM_SAMPLES * adc_bits + TIME_W + 7) / 8) * 8;
  endfunction

  function automatic int out_width(input int adc_bits);
    return ((3 * adc_bits + 4 + 7) / 8) * 8;
  endfunction

endpackage

`default_nettype wire

[design/adaptive_light_threshold_switch.sv]
// The result register takes the processed input word when empty or being read.
// Throughput: one word per cycle while out_tready is high; the only loop is the
// min/max, class and debounce register update in the single processing stage.
// A stalled result register holds the input register: it takes one more word,
// then in_tready drops until the output side takes the waiting result.
// Reset (rst_n low, synchronous): empties both stages, resets state, delay = 50.
`default_nettype none

module adaptive_light_threshold_switch
  import alts_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: sample_0 .. sample_7, now_ms, zero fill
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [in_width(ADC_BITS)-1:0]    in_tdata,
  // in_tuser: button_level
  input  logic                             in_tuser,
  // out_tdata: average, low_seen, high_seen, is_bright, is_swapped,
  //            red_on, green_on, zero fill
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [out_width(ADC_BITS)-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [DELAY_W-1:0]               cfg_data
);

  localparam int OUT_W = out_width(ADC_BITS);
  localparam int SMP_W = NUM_SAMPLES * ADC_BITS;

  logic               in_vld_r;
  logic [SMP_W-1:0]   smp_r;
  logic [TIME_W-1:0]  now_r;
  logic               btn_r;
  logic               out_vld_r;
  logic [OUT_W-1:0]   out_r;
  logic [DELAY_W-1:0] delay_r;

  logic                advance;
  logic                fire;
  logic [ADC_BITS-1:0] avg;
  logic [ADC_BITS-1:0] min_nxt;
  logic [ADC_BITS-1:0] max_nxt;
  logic                bright_nxt;
  logic                swap_nxt;
  logic                red;
  logic [OUT_W-1:0]    out_nxt;

  assign advance   = !out_vld_r || out_tready;
  assign fire      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (cfg_valid) begin
      delay_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      smp_r <= in_tdata[SMP_W-1:0];
      now_r <= in_tdata[SMP_W +: TIME_W];
      btn_r <= in_tuser;
    end
  end

  alts_debounce u_debounce (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (fire),
    .level    (btn_r),
    .now_ms   (now_r),
    .delay_ms (delay_r),
    .swap_nxt (swap_nxt)
  );

  alts_classify #(
    .ADC_BITS (ADC_BITS)
  ) u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (fire),
    .samples    (smp_r),
    .avg        (avg),
    .min_nxt    (min_nxt),
    .max_nxt    (max_nxt),
    .bright_nxt (bright_nxt)
  );

  assign red     = bright_nxt ^ swap_nxt;
  assign out_nxt = OUT_W'({!red, red, swap_nxt, bright_nxt, max_nxt, min_nxt, avg});

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

[design/alts_debounce.sv]
// Button debouncer against the word timestamp, with the LED swap toggle.
`default_nettype none

module alts_debounce
  import alts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               level,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic [DELAY_W-1:0] delay_ms,
  output logic               swap_nxt
);

  logic              last_r;
  logic              stable_r;
  logic [TIME_W-1:0] chg_r;
  logic              swap_r;

  logic              last_nxt;
  logic              stable_nxt;
  logic [TIME_W-1:0] chg_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              take;

  always_comb begin
    last_nxt   = level;
    chg_nxt    = (level != last_r) ? now_ms : chg_r;
    // unsigned difference, so a backwards timestamp reads as a long hold
    elapsed    = now_ms - chg_nxt;
    take       = (elapsed > TIME_W'(delay_ms)) && (level != stable_r);
    stable_nxt = take ? level : stable_r;
    // toggle on each newly accepted press
    swap_nxt   = swap_r ^ (take && !level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= 1'b1;
      stable_r <= 1'b1;
      chg_r    <= '0;
      swap_r   <= 1'b0;
    end else if (en) begin
      last_r   <= last_nxt;
      stable_r <= stable_nxt;
      chg_r    <= chg_nxt;
      swap_r   <= swap_nxt;
    end
  end

endmodule

`default_nettype wire

[design/alts_classify.sv]
// Sample averaging, min/max tracking and midpoint classification with hysteresis.
`default_nettype none

module alts_classify
  import alts_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [NUM_SAMPLES*ADC_BITS-1:0] samples,
  output logic [ADC_BITS-1:0]             avg,
  output logic [ADC_BITS-1:0]             min_nxt,
  output logic [ADC_BITS-1:0]             max_nxt,
  output logic                            bright_nxt
);

  localparam int SUM_W  = ADC_BITS + SAMPLE_SHIFT;
  // span/20 = (span/4)/5, the divide by 5 as a reciprocal multiply
  localparam int QX_W   = ADC_BITS - 2;
  localparam int RSH    = ADC_BITS + 2;
  localparam int RECIP  = (2 ** RSH + 4) / 5;
  localparam int PROD_W = QX_W + RSH;

  logic [ADC_BITS-1:0] min_r;
  logic [ADC_BITS-1:0] max_r;
  logic                seeded_r;
  logic                bright_r;

  logic [SUM_W-1:0]    sum;
  logic [ADC_BITS:0]   mid_sum;
  logic [ADC_BITS-1:0] mid;
  logic [ADC_BITS-1:0] span;
  logic [PROD_W-1:0]   prod;
  logic [QX_W-1:0]     quo;
  logic [QX_W-1:0]     band;
  logic [ADC_BITS:0]   lo_side;
  logic [ADC_BITS:0]   hi_side;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      sum = sum + SUM_W'(samples[i*ADC_BITS +: ADC_BITS]);
    end
    avg = sum[SUM_W-1:SAMPLE_SHIFT];

    // first word seeds both extremes
    if (!seeded_r) begin
      min_nxt = avg;
      max_nxt = avg;
    end else begin
      min_nxt = (avg < min_r) ? avg : min_r;
      max_nxt = (avg > max_r) ? avg : max_r;
    end

    mid_sum = (ADC_BITS+1)'(min_nxt) + (ADC_BITS+1)'(max_nxt);
    mid     = mid_sum[ADC_BITS:1];
    span    = max_nxt - min_nxt;
    prod    = PROD_W'(span[ADC_BITS-1:2]) * PROD_W'(RECIP);
    quo     = prod[PROD_W-1:RSH];
    band    = (quo == '0) ? QX_W'(1) : quo;

    // avg < mid - band and avg > mid + band, kept unsigned
    lo_side = (ADC_BITS+1)'(avg) + (ADC_BITS+1)'(band);
    hi_side = (ADC_BITS+1)'(mid) + (ADC_BITS+1)'(band);
    if (lo_side < (ADC_BITS+1)'(mid)) begin
      bright_nxt = 1'b1;
    end else if ((ADC_BITS+1)'(avg) > hi_side) begin
      bright_nxt = 1'b0;
    end else begin
      bright_nxt = bright_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= '0;
      max_r    <= '0;
      seeded_r <= 1'b0;
      bright_r <= 1'b1;
    end else if (en) begin
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      seeded_r <= 1'b1;
      bright_r <= bright_nxt;
    end
  end

endmodule

`default_nettype wire

[design/alts_check.sv]
// Port-level checker for the light threshold switch, bound to the top level.
`default_nettype none

module alts_check
  import alts_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [out_width(ADC_BITS)-1:0] out_tdata
);

  localparam int AB = ADC_BITS;
  localparam int BRIGHT_BIT = 3 * AB;
  localparam int SWAP_BIT   = 3 * AB + 1;
  localparam int RED_BIT    = 3 * AB + 2;
  localparam int GREEN_BIT  = 3 * AB + 3;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_led_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[GREEN_BIT] != out_tdata[RED_BIT])
    else $error("red and green LEDs not complementary");

  a_led_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[RED_BIT] == (out_tdata[BRIGHT_BIT] ^ out_tdata[SWAP_BIT]))
    else $error("red LED does not follow class and swap");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[AB +: AB] <= out_tdata[0 +: AB]) &&
                   (out_tdata[0 +: AB] <= out_tdata[2*AB +: AB]))
    else $error("average outside the seen range");

endmodule

bind adaptive_light_threshold_switch alts_check #(
  .ADC_BITS (ADC_BITS)
) u_alts_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
